### rtl/ent_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ent_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VOL_W           = 32;
  localparam int SMP_W           = 31;
  localparam int ENT_W           = 19;
  localparam int LOG_FRAC        = 24;
  localparam int P_W             = 33;
  localparam int MANT_W          = 32;
  localparam int ACC_W           = 32;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LT_GO,
    S_LT_WAIT,
    S_LT_SAVE,
    S_RD,
    S_V_GO,
    S_V_WAIT,
    S_MUL,
    S_ACC,
    S_SCALE,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic ingest;
    logic start_calc;
    logic log_go;
    logic log_sel_total;
    logic lt_save;
    logic div_go;
    logic mul;
    logic acc_add;
    logic scale;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic log_busy;
    logic div_busy;
    logic last_idx;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/ent_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ent_smp_if;
  logic                           valid;
  logic                           ready;
  logic signed [ent_pkg::VOL_W-1:0] volume;
  logic                           end_of_set;

  modport source (output valid, output volume, output end_of_set, input ready);
  modport sink (input valid, input volume, input end_of_set, output ready);
endinterface

interface ent_res_if;
  logic                      valid;
  logic                      ready;
  logic [ent_pkg::ENT_W-1:0] entropy;
  logic                      overflow;

  modport source (output valid, output entropy, output overflow, input ready);
  modport sink (input valid, input entropy, input overflow, output ready);
endinterface
`default_nettype wire

### rtl/ent_log.sv
`timescale 1ns / 1ps
`default_nettype none
// log2 of x >= 1: one bit of normalization per cycle, then one squaring per fraction bit
module ent_log #(
  parameter int LW = 41
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic [LW-1:0]                           x,
  output logic                                         busy,
  output logic [$clog2(LW)+ent_pkg::LOG_FRAC-1:0]      result
);
  localparam int TOPW = $clog2(LW);
  localparam int CNTW = $clog2(ent_pkg::LOG_FRAC);

  logic                          norm;
  logic [LW-1:0]                 n;
  logic [TOPW-1:0]               sh;
  logic [ent_pkg::MANT_W-1:0]    m;
  logic [ent_pkg::MANT_W-1:0]    m_next;
  logic [ent_pkg::LOG_FRAC-1:0]  frac;
  logic [CNTW-1:0]               cnt;
  logic [2*ent_pkg::MANT_W-1:0]  sq;
  logic                          fbit;

  always_comb begin
    sq   = m * m;
    fbit = sq[2*ent_pkg::MANT_W-1];
    if (fbit) begin
      m_next = sq[2*ent_pkg::MANT_W-1:ent_pkg::MANT_W];
    end else begin
      m_next = sq[2*ent_pkg::MANT_W-2:ent_pkg::MANT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      norm <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      norm <= 1'b1;
      n    <= x;
      sh   <= '0;
      cnt  <= '0;
      frac <= '0;
    end else if (busy) begin
      if (norm) begin
        if (n[LW-1]) begin
          norm <= 1'b0;
          m    <= n[LW-1 -: ent_pkg::MANT_W];
        end else begin
          n  <= n << 1;
          sh <= sh + TOPW'(1);
        end
      end else begin
        m    <= m_next;
        frac <= {frac[ent_pkg::LOG_FRAC-2:0], fbit};
        cnt  <= cnt + CNTW'(1);
        if (cnt == CNTW'(ent_pkg::LOG_FRAC - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = {TOPW'(LW - 1) - sh, frac};

endmodule
`default_nettype wire

### rtl/ent_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divide: quo = (v << 32) / total, one quotient bit per cycle, v <= total
module ent_div #(
  parameter int TW = 42
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ent_pkg::SMP_W-1:0]   v,
  input  wire logic [TW-1:0]               total,
  output logic                             busy,
  output logic [ent_pkg::P_W-1:0]          quo
);
  localparam int CNTW = $clog2(ent_pkg::P_W);

  logic [TW:0]     r;
  logic [TW:0]     rs;
  logic            ge;
  logic [CNTW-1:0] cnt;

  always_comb begin
    ge = r >= {1'b0, total};
    rs = ge ? (r - {1'b0, total}) : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      r    <= (TW+1)'(v);
      quo  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      quo <= {quo[ent_pkg::P_W-2:0], ge};
      r   <= {rs[TW-1:0], 1'b0};
      cnt <= cnt + CNTW'(1);
      if (cnt == CNTW'(ent_pkg::P_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ent_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ent_dp #(
  parameter int MAX_SAMPLES = ent_pkg::MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = ent_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ent_pkg::ctrl_cmd_t               cmd,
  output ent_pkg::dp_sts_t                      sts,
  input  wire logic signed [ent_pkg::VOL_W-1:0] volume,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ent_pkg::ENT_W-1:0]             entropy,
  output logic                                  overflow
);
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int TW   = ent_pkg::SMP_W + CW;
  localparam int LRW  = $clog2(TW) + ent_pkg::LOG_FRAC;
  localparam int PW   = ent_pkg::P_W + LRW;
  localparam int SW   = 2 * ent_pkg::ACC_W;

  logic [ent_pkg::SMP_W-1:0] mem [MAX_SAMPLES];
  logic [ent_pkg::SMP_W-1:0] rd_data;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  logic [TW-1:0]             total;
  logic                      drop;
  logic [LRW-1:0]            log_total;
  logic [PW-1:0]             prod;
  logic [ent_pkg::ACC_W-1:0] acc;
  logic [SW-1:0]             sprod;

  logic                      pos;
  logic                      full;
  logic [TW-1:0]             log_x;
  logic                      log_busy;
  logic [LRW-1:0]            log_res;
  logic                      div_busy;
  logic [ent_pkg::P_W-1:0]   quo;
  logic [LRW-1:0]            d;
  logic [SW:0]               rsum;
  logic [SW:0]               rq;
  logic [ent_pkg::ENT_W-1:0] ent_sat;

  assign pos   = !volume[ent_pkg::VOL_W-1] && (volume != '0);
  assign full  = count == CW'(MAX_SAMPLES);
  assign log_x = cmd.log_sel_total ? total : TW'(rd_data);
  assign d     = (log_total > log_res) ? (log_total - log_res) : '0;

  always_comb begin
    rsum = {1'b0, sprod} + ((SW+1)'(1) << (55 - FRAC_BITS));
    rq   = rsum >> (56 - FRAC_BITS);
    if (|rq[SW:ent_pkg::ENT_W]) begin
      ent_sat = '1;
    end else begin
      ent_sat = rq[ent_pkg::ENT_W-1:0];
    end
  end

  ent_log #(.LW(TW)) u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_go),
    .x      (log_x),
    .busy   (log_busy),
    .result (log_res)
  );

  ent_div #(.TW(TW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .v     (rd_data),
    .total (total),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.ingest && pos && !full) begin
      mem[count[AW-1:0]] <= volume[ent_pkg::SMP_W-1:0];
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ingest && pos) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + CW'(1);
          total <= total + TW'(volume[ent_pkg::SMP_W-1:0]);
        end
      end
      if (cmd.load_out) begin
        count     <= '0;
        total     <= '0;
        drop      <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_calc) begin
      acc <= '0;
      idx <= '0;
    end
    if (cmd.lt_save) begin
      log_total <= log_res;
    end
    if (cmd.mul) begin
      prod <= quo * d;
    end
    if (cmd.acc_add) begin
      acc <= acc + ent_pkg::ACC_W'(prod >> 32);
      idx <= idx + CW'(1);
    end
    if (cmd.scale) begin
      sprod <= acc * ent_pkg::LN2_Q32;
    end
    if (cmd.load_out) begin
      entropy  <= ent_sat;
      overflow <= drop;
    end
  end

  always_comb begin
    sts.total_zero = total == '0;
    sts.log_busy   = log_busy;
    sts.div_busy   = div_busy;
    sts.last_idx   = (idx + CW'(1)) == count;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

### rtl/ent_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ent_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             end_of_set,
  output logic                  in_ready,
  output ent_pkg::ctrl_cmd_t    cmd,
  input  wire ent_pkg::dp_sts_t sts
);
  ent_pkg::ctrl_state_t state;
  ent_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ent_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ent_pkg::S_IDLE: begin
        if (in_valid && end_of_set) state_next = ent_pkg::S_START;
      end
      ent_pkg::S_START: begin
        state_next = sts.total_zero ? ent_pkg::S_SCALE : ent_pkg::S_LT_GO;
      end
      ent_pkg::S_LT_GO:   state_next = ent_pkg::S_LT_WAIT;
      ent_pkg::S_LT_WAIT: begin
        if (!sts.log_busy) state_next = ent_pkg::S_LT_SAVE;
      end
      ent_pkg::S_LT_SAVE: state_next = ent_pkg::S_RD;
      ent_pkg::S_RD:      state_next = ent_pkg::S_V_GO;
      ent_pkg::S_V_GO:    state_next = ent_pkg::S_V_WAIT;
      ent_pkg::S_V_WAIT: begin
        if (!sts.log_busy && !sts.div_busy) state_next = ent_pkg::S_MUL;
      end
      ent_pkg::S_MUL:     state_next = ent_pkg::S_ACC;
      ent_pkg::S_ACC: begin
        state_next = sts.last_idx ? ent_pkg::S_SCALE : ent_pkg::S_RD;
      end
      ent_pkg::S_SCALE:   state_next = ent_pkg::S_FIN;
      ent_pkg::S_FIN: begin
        if (sts.out_free) state_next = ent_pkg::S_IDLE;
      end
      default:            state_next = ent_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ent_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ingest = in_valid;
      end
      ent_pkg::S_START:   cmd.start_calc = 1'b1;
      ent_pkg::S_LT_GO: begin
        cmd.log_go        = 1'b1;
        cmd.log_sel_total = 1'b1;
      end
      ent_pkg::S_LT_SAVE: cmd.lt_save = 1'b1;
      ent_pkg::S_V_GO: begin
        cmd.log_go = 1'b1;
        cmd.div_go = 1'b1;
      end
      ent_pkg::S_MUL:     cmd.mul = 1'b1;
      ent_pkg::S_ACC:     cmd.acc_add = 1'b1;
      ent_pkg::S_SCALE:   cmd.scale = 1'b1;
      ent_pkg::S_FIN:     cmd.load_out = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/shannon_entropy_of_weights_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Fields                          Word accepted
// samples  in   volume[31:0] s, end_of_set      valid && ready
// result   out  entropy[18:0] Q3.16, overflow   valid && ready
//
// One sample word is taken per cycle while valid, and only while no set is in flight.
// After end_of_set: a start state; unless the total is zero, log2 of the total and,
// per stored sample, a read, a log2 on the shared one-bit-per-cycle log unit beside
// the 33-step divider, a multiply and an accumulate; then scale and load the result.
// Reset clears FSM, count, total, drop and out_valid; memory needs no clearing pass.
// A stalled result waits in the output register while the next set streams in.
module shannon_entropy_of_weights_unit #(
  parameter int MAX_SAMPLES = ent_pkg::MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = ent_pkg::FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  ent_smp_if.sink    samples,
  ent_res_if.source  result
);
  ent_pkg::ctrl_cmd_t cmd;
  ent_pkg::dp_sts_t   sts;

  ent_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .end_of_set (samples.end_of_set),
    .in_ready   (samples.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ent_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .volume    (samples.volume),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .entropy   (result.entropy),
    .overflow  (result.overflow)
  );

endmodule
`default_nettype wire

### rtl/ent_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ent_chk (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      end_of_set,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [ent_pkg::ENT_W-1:0] entropy,
  input wire logic                      overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entropy) && $stable(overflow))
    else $error("result word changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_set |=> !in_ready)
    else $error("samples taken right after end of set");

  a_result_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a compute pass");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind shannon_entropy_of_weights_unit ent_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .end_of_set (samples.end_of_set),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .entropy    (result.entropy),
  .overflow   (result.overflow)
);
`default_nettype wire
